[design/segmented_range_kv_index_unit_defines.svh]
// assertion macros for the segmented range key-value index
// used by segmented_range_kv_index_unit; expects clk and rst_n in scope
`ifndef SEGMENTED_RANGE_KV_INDEX_UNIT_DEFINES_SVH
`define SEGMENTED_RANGE_KV_INDEX_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define SRKV_ASSERT_IMP(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("segmented range kv index check failed");

// next-cycle implication, held off during reset
`define SRKV_ASSERT_NXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("segmented range kv index check failed");

`endif

[design/srkv_pkg.sv]
// shared types and codes for the segmented range key-value index
// no dependencies
package srkv_pkg;

    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int ACC_BITS   = 32;
    localparam int CFG_BITS   = 32;

    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [ACC_BITS-1:0]   acc_t;
    typedef logic [2:0]            cmd_t;
    typedef logic [1:0]            status_t;

    // commands
    localparam cmd_t CMD_INSERT = 3'd0;
    localparam cmd_t CMD_DELETE = 3'd1;
    localparam cmd_t CMD_QUERY  = 3'd2;
    localparam cmd_t CMD_SCAN   = 3'd3;
    localparam cmd_t CMD_MERGE  = 3'd4;
    localparam cmd_t CMD_INFO   = 3'd5;

    // result status
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_BAD_SEG   = 2'd2;
    localparam status_t ST_FULL      = 2'd3;

    // configuration register indexes
    localparam logic CFG_SPLIT_CAPACITY = 1'b0;
    localparam logic CFG_HOT_THRESHOLD  = 1'b1;

    localparam logic [2:0] SPLIT_CAP_RESET = 3'd6;
    localparam acc_t       HOT_THR_RESET   = 32'd1000;

    typedef struct packed {
        status_t    status;
        key_t       key;
        key_t       key_end;
        value_t     value;
        logic [3:0] segs;
        logic [3:0] ents;
        acc_t       acc;
        logic       hot;
        logic       last;
    } result_t;

endpackage

[design/segmented_range_kv_index_unit.sv]
// segmented range key-value index, top level with sequencer, segment table and entry memory
// depends on srkv_pkg and segmented_range_kv_index_unit_defines.svh
//
// usage:
//   input channel (in_valid/in_stall) carries one command per transfer: insert, delete,
//   point query, range scan, merge or segment info. in_stall is high while a command is
//   being worked, so one command is in flight at a time.
//   output channel (out_valid/out_stall) returns the results; the final one of a command
//   has last set. a scan gives one transfer per match, or one not-found transfer.
//   config port (cfg_we/cfg_index/cfg_data) writes split_capacity and hot_threshold;
//   write only while the block is idle.
// pacing:
//   a command walks the segment table segment by segment, then reads entries one at a time;
//   every entry step goes through the entry memory (one write port, one registered read),
//   which sets the pace: a split rewrites the segment's entries, a merge moves b's entries
//   and shifts the later segments' table rows and entries down, a full scan reads every entry.
// reset: one segment covers all keys, counts and hot flags clear; the entry memory is
//   not cleared, no clearing pass is needed since only filled slots are read.
// a stalled output holds its result; the sequencer waits before loading the next one.
module segmented_range_kv_index_unit
    import srkv_pkg::*;
#(
    parameter int MAX_SEGMENTS  = 8,
    parameter int SEGMENT_SLOTS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    // command channel
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [2:0]    command,
    input  key_t          key,
    input  key_t          key_high,
    input  value_t        value,
    input  logic [2:0]    seg_first,
    input  logic [2:0]    seg_second,
    // result channel
    output logic          out_valid,
    input  logic          out_stall,
    output logic [1:0]    status,
    output key_t          out_key,
    output key_t          out_key_end,
    output value_t        out_value,
    output logic [3:0]    segments_in_use,
    output logic [3:0]    entries_in_segment,
    output acc_t          access_total,
    output logic          hot_mark,
    output logic          last,
    // configuration writes
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

`include "segmented_range_kv_index_unit_defines.svh"

    localparam int SEG_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int ECNT_W  = $clog2(SEGMENT_SLOTS + 1);
    localparam int TOTAL   = MAX_SEGMENTS * SEGMENT_SLOTS;
    localparam int ADDR_W  = $clog2(TOTAL);

    // sequencer states
    localparam logic [4:0] S_IDLE       = 5'd0;
    localparam logic [4:0] S_LOC        = 5'd1;
    localparam logic [4:0] S_FIND_RD    = 5'd2;
    localparam logic [4:0] S_FIND_CMP   = 5'd3;
    localparam logic [4:0] S_ACT        = 5'd4;
    localparam logic [4:0] S_SPLIT_DIFF = 5'd5;
    localparam logic [4:0] S_SPLIT_MID  = 5'd6;
    localparam logic [4:0] S_SPLIT_SEG  = 5'd7;
    localparam logic [4:0] S_SPLIT_RD   = 5'd8;
    localparam logic [4:0] S_SPLIT_WR   = 5'd9;
    localparam logic [4:0] S_DEL_RD     = 5'd10;
    localparam logic [4:0] S_DEL_WR     = 5'd11;
    localparam logic [4:0] S_SCAN_SEG   = 5'd12;
    localparam logic [4:0] S_SCAN_RD    = 5'd13;
    localparam logic [4:0] S_SCAN_CMP   = 5'd14;
    localparam logic [4:0] S_SCAN_END   = 5'd15;
    localparam logic [4:0] S_MRG_CHK    = 5'd16;
    localparam logic [4:0] S_MRG_A      = 5'd17;
    localparam logic [4:0] S_MRG_B      = 5'd18;
    localparam logic [4:0] S_MRG_RD     = 5'd19;
    localparam logic [4:0] S_MRG_WR     = 5'd20;
    localparam logic [4:0] S_SHF_TAB    = 5'd21;
    localparam logic [4:0] S_SHF_RD     = 5'd22;
    localparam logic [4:0] S_SHF_WR     = 5'd23;
    localparam logic [4:0] S_INFO       = 5'd24;
    localparam logic [4:0] S_RESP       = 5'd25;

    // entry memory address: segment row plus slot
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SEG_W-1:0] seg,
                                                    input logic [ECNT_W-1:0] off);
        slot_addr = ADDR_W'(ADDR_W'(seg) * ADDR_W'(SEGMENT_SLOTS)) + ADDR_W'(off);
    endfunction

    // control state (reset)
    logic [4:0]        state_reg, state_next;
    key_t              seg_start_reg [MAX_SEGMENTS];
    key_t              seg_start_next [MAX_SEGMENTS];
    key_t              seg_end_reg [MAX_SEGMENTS];
    key_t              seg_end_next [MAX_SEGMENTS];
    logic [ECNT_W-1:0] seg_cnt_reg [MAX_SEGMENTS];
    logic [ECNT_W-1:0] seg_cnt_next [MAX_SEGMENTS];
    acc_t              seg_acc_reg [MAX_SEGMENTS];
    acc_t              seg_acc_next [MAX_SEGMENTS];
    logic              seg_hot_reg [MAX_SEGMENTS];
    logic              seg_hot_next [MAX_SEGMENTS];
    logic [CNT_W-1:0]  seg_total_reg, seg_total_next;
    logic [2:0]        split_cap_reg, split_cap_next;
    acc_t              hot_thr_reg, hot_thr_next;
    logic              out_valid_reg, out_valid_next;
    logic              pend_valid_reg, pend_valid_next;

    // working registers (no reset)
    cmd_t              cmd_reg, cmd_next;
    key_t              key_reg, key_next;
    key_t              khi_reg, khi_next;
    value_t            val_reg, val_next;
    logic [2:0]        sa_reg, sa_next;
    logic [2:0]        sb_reg, sb_next;
    logic [SEG_W-1:0]  seg_idx_reg, seg_idx_next;
    logic [ECNT_W-1:0] slot_reg, slot_next;
    logic [ECNT_W-1:0] pos_reg, pos_next;
    logic              found_reg, found_next;
    key_t              diff_reg, diff_next;
    key_t              mid_reg, mid_next;
    logic [ECNT_W-1:0] keep_reg, keep_next;
    logic [ECNT_W-1:0] moved_reg, moved_next;
    logic [SEG_W-1:0]  a_seg_reg, a_seg_next;
    logic [SEG_W-1:0]  b_seg_reg, b_seg_next;
    key_t              a_end_reg, a_end_next;
    logic [ECNT_W-1:0] a_cnt_reg, a_cnt_next;
    acc_t              a_acc_reg, a_acc_next;
    logic              a_hot_reg, a_hot_next;
    key_t              pend_key_reg, pend_key_next;
    value_t            pend_val_reg, pend_val_next;
    result_t           resp_reg, resp_next;
    result_t           res_reg, res_next;

    // entry memory
    key_t              entry_keys_mem [TOTAL];
    value_t            entry_values_mem [TOTAL];
    key_t              rd_key_reg;
    value_t            rd_val_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    key_t              mem_wkey;
    value_t            mem_wval;

    // selected segment row
    key_t              rs_start;
    key_t              rs_end;
    logic [ECNT_W-1:0] rs_cnt;
    acc_t              rs_acc;
    logic              rs_hot;

    // shared compare and arithmetic
    logic              last_seg;
    logic              slot_lt_cnt;
    acc_t              touch_acc;
    logic              touch_hot;
    logic [ECNT_W-1:0] cnt_inc;
    logic              key_in_seg;
    logic              seg_overlap;
    logic              rd_in_range;
    logic              split_go;
    logic [ACC_BITS:0] acc_sum;
    acc_t              acc_sat;
    key_t              a_end_inc;
    logic [ECNT_W:0]   cnt_sum;
    logic              out_free;
    logic              in_xfer;
    logic              emit_en;
    result_t           emit_res;
    logic              info_bad;
    logic              merge_bad;

    assign rs_start = seg_start_reg[seg_idx_reg];
    assign rs_end   = seg_end_reg[seg_idx_reg];
    assign rs_cnt   = seg_cnt_reg[seg_idx_reg];
    assign rs_acc   = seg_acc_reg[seg_idx_reg];
    assign rs_hot   = seg_hot_reg[seg_idx_reg];

    assign last_seg    = (CNT_W'(seg_idx_reg) + CNT_W'(1)) >= seg_total_reg;
    assign slot_lt_cnt = slot_reg < rs_cnt;
    // access count saturates at all ones
    assign touch_acc   = (rs_acc == '1) ? rs_acc : rs_acc + ACC_BITS'(1);
    assign touch_hot   = touch_acc > hot_thr_reg;
    assign cnt_inc     = rs_cnt + ECNT_W'(1);
    assign key_in_seg  = (key_reg >= rs_start) && (key_reg <= rs_end);
    assign seg_overlap = !((rs_end < key_reg) || (rs_start > khi_reg));
    assign rd_in_range = (rd_key_reg >= key_reg) && (rd_key_reg <= khi_reg);
    assign split_go    = (8'(cnt_inc) > 8'(split_cap_reg))
                      && (seg_total_reg < CNT_W'(MAX_SEGMENTS))
                      && (rs_start < rs_end);
    assign acc_sum     = {1'b0, a_acc_reg} + {1'b0, rs_acc};
    assign acc_sat     = acc_sum[ACC_BITS] ? '1 : acc_sum[ACC_BITS-1:0];
    assign a_end_inc   = a_end_reg + KEY_BITS'(1);
    assign cnt_sum     = (ECNT_W+1)'(a_cnt_reg) + (ECNT_W+1)'(rs_cnt);
    assign info_bad    = (CNT_W+3)'(sa_reg) >= (CNT_W+3)'(seg_total_reg);
    assign merge_bad   = ((CNT_W+3)'(sa_reg) >= (CNT_W+3)'(seg_total_reg))
                      || ((CNT_W+3)'(sb_reg) >= (CNT_W+3)'(seg_total_reg))
                      || (sa_reg == sb_reg);

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        seg_start_next  = seg_start_reg;
        seg_end_next    = seg_end_reg;
        seg_cnt_next    = seg_cnt_reg;
        seg_acc_next    = seg_acc_reg;
        seg_hot_next    = seg_hot_reg;
        seg_total_next  = seg_total_reg;
        split_cap_next  = split_cap_reg;
        hot_thr_next    = hot_thr_reg;
        pend_valid_next = pend_valid_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        khi_next        = khi_reg;
        val_next        = val_reg;
        sa_next         = sa_reg;
        sb_next         = sb_reg;
        seg_idx_next    = seg_idx_reg;
        slot_next       = slot_reg;
        pos_next        = pos_reg;
        found_next      = found_reg;
        diff_next       = diff_reg;
        mid_next        = mid_reg;
        keep_next       = keep_reg;
        moved_next      = moved_reg;
        a_seg_next      = a_seg_reg;
        b_seg_next      = b_seg_reg;
        a_end_next      = a_end_reg;
        a_cnt_next      = a_cnt_reg;
        a_acc_next      = a_acc_reg;
        a_hot_next      = a_hot_reg;
        pend_key_next   = pend_key_reg;
        pend_val_next   = pend_val_reg;
        resp_next       = resp_reg;
        mem_we          = 1'b0;
        mem_waddr       = slot_addr(seg_idx_reg, slot_reg);
        mem_wkey        = rd_key_reg;
        mem_wval        = rd_val_reg;
        mem_raddr       = slot_addr(seg_idx_reg, slot_reg);
        emit_en         = 1'b0;
        emit_res        = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SPLIT_CAPACITY: split_cap_next = cfg_data[2:0];
                CFG_HOT_THRESHOLD:  hot_thr_next   = cfg_data[ACC_BITS-1:0];
                default:            split_cap_next = split_cap_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next   = command;
                    key_next   = key;
                    khi_next   = key_high;
                    // scan bounds given reversed are swapped
                    if (command == CMD_SCAN && key > key_high)
                    begin
                        key_next = key_high;
                        khi_next = key;
                    end
                    val_next        = value;
                    sa_next         = seg_first;
                    sb_next         = seg_second;
                    slot_next       = '0;
                    found_next      = 1'b0;
                    pend_valid_next = 1'b0;
                    resp_next       = '0;
                    resp_next.last  = 1'b1;
                    seg_idx_next    = (command == CMD_INFO) ? SEG_W'(seg_first) : '0;
                    case (command)
                        CMD_INSERT: state_next = S_LOC;
                        CMD_DELETE: state_next = S_LOC;
                        CMD_QUERY:  state_next = S_LOC;
                        CMD_SCAN:   state_next = S_SCAN_SEG;
                        CMD_MERGE:  state_next = S_MRG_CHK;
                        CMD_INFO:   state_next = S_INFO;
                        default:
                        begin
                            resp_next.status = ST_BAD_SEG;
                            state_next       = S_RESP;
                        end
                    endcase
                end
            end

            // walk the table for the first segment holding the key
            S_LOC:
            begin
                if (key_in_seg)
                begin
                    slot_next  = '0;
                    state_next = S_FIND_RD;
                end
                else if (last_seg)
                begin
                    seg_idx_next = '0;
                    slot_next    = '0;
                    state_next   = S_FIND_RD;
                end
                else
                begin
                    seg_idx_next = seg_idx_reg + SEG_W'(1);
                end
            end

            S_FIND_RD:
            begin
                state_next = slot_lt_cnt ? S_FIND_CMP : S_ACT;
            end

            S_FIND_CMP:
            begin
                if (rd_key_reg == key_reg)
                begin
                    found_next = 1'b1;
                    pos_next   = slot_reg;
                    if (cmd_reg == CMD_QUERY)
                        resp_next.value = rd_val_reg;
                    state_next = S_ACT;
                end
                else
                begin
                    slot_next  = slot_reg + ECNT_W'(1);
                    state_next = S_FIND_RD;
                end
            end

            S_ACT:
            begin
                state_next = S_RESP;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (found_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = slot_addr(seg_idx_reg, pos_reg);
                            mem_wkey  = key_reg;
                            mem_wval  = val_reg;
                            seg_acc_next[seg_idx_reg] = touch_acc;
                            seg_hot_next[seg_idx_reg] = touch_hot;
                        end
                        else if (rs_cnt >= ECNT_W'(SEGMENT_SLOTS))
                        begin
                            resp_next.status = ST_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = slot_addr(seg_idx_reg, rs_cnt);
                            mem_wkey  = key_reg;
                            mem_wval  = val_reg;
                            seg_cnt_next[seg_idx_reg] = cnt_inc;
                            seg_acc_next[seg_idx_reg] = touch_acc;
                            seg_hot_next[seg_idx_reg] = touch_hot;
                            if (split_go)
                                state_next = S_SPLIT_DIFF;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (found_reg)
                        begin
                            slot_next  = pos_reg;
                            state_next = S_DEL_RD;
                        end
                        else
                        begin
                            resp_next.status = ST_NOT_FOUND;
                        end
                    end
                    CMD_QUERY:
                    begin
                        if (found_reg)
                        begin
                            seg_acc_next[seg_idx_reg] = touch_acc;
                            seg_hot_next[seg_idx_reg] = touch_hot;
                        end
                        else
                        begin
                            resp_next.status = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        resp_next.status = ST_BAD_SEG;
                    end
                endcase
            end

            // split at the midpoint, upper half goes to a new segment at the end
            S_SPLIT_DIFF:
            begin
                diff_next  = rs_end - rs_start;
                state_next = S_SPLIT_MID;
            end

            S_SPLIT_MID:
            begin
                mid_next   = rs_start + (diff_reg >> 1);
                state_next = S_SPLIT_SEG;
            end

            S_SPLIT_SEG:
            begin
                seg_end_next[seg_idx_reg]                = mid_reg;
                seg_start_next[SEG_W'(seg_total_reg)]    = mid_reg + KEY_BITS'(1);
                seg_end_next[SEG_W'(seg_total_reg)]      = rs_end;
                seg_acc_next[SEG_W'(seg_total_reg)]      = '0;
                seg_hot_next[SEG_W'(seg_total_reg)]      = 1'b0;
                slot_next  = '0;
                keep_next  = '0;
                moved_next = '0;
                state_next = S_SPLIT_RD;
            end

            S_SPLIT_RD:
            begin
                if (slot_lt_cnt)
                begin
                    state_next = S_SPLIT_WR;
                end
                else
                begin
                    seg_cnt_next[seg_idx_reg]             = keep_reg;
                    seg_cnt_next[SEG_W'(seg_total_reg)]   = moved_reg;
                    seg_total_next = seg_total_reg + CNT_W'(1);
                    state_next     = S_RESP;
                end
            end

            S_SPLIT_WR:
            begin
                mem_we = 1'b1;
                if (rd_key_reg > mid_reg)
                begin
                    mem_waddr  = slot_addr(SEG_W'(seg_total_reg), moved_reg);
                    moved_next = moved_reg + ECNT_W'(1);
                end
                else
                begin
                    mem_waddr = slot_addr(seg_idx_reg, keep_reg);
                    keep_next = keep_reg + ECNT_W'(1);
                end
                slot_next  = slot_reg + ECNT_W'(1);
                state_next = S_SPLIT_RD;
            end

            // close the gap left by a deleted entry
            S_DEL_RD:
            begin
                mem_raddr = slot_addr(seg_idx_reg, slot_reg + ECNT_W'(1));
                if ((slot_reg + ECNT_W'(1)) < rs_cnt)
                begin
                    state_next = S_DEL_WR;
                end
                else
                begin
                    seg_cnt_next[seg_idx_reg] = rs_cnt - ECNT_W'(1);
                    state_next = S_RESP;
                end
            end

            S_DEL_WR:
            begin
                mem_we     = 1'b1;
                slot_next  = slot_reg + ECNT_W'(1);
                state_next = S_DEL_RD;
            end

            // scan: segment order, then entry order; one match held back for last
            S_SCAN_SEG:
            begin
                if (seg_overlap)
                begin
                    slot_next  = '0;
                    state_next = S_SCAN_RD;
                end
                else if (last_seg)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    seg_idx_next = seg_idx_reg + SEG_W'(1);
                end
            end

            S_SCAN_RD:
            begin
                if (slot_lt_cnt)
                begin
                    state_next = S_SCAN_CMP;
                end
                else if (last_seg)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    seg_idx_next = seg_idx_reg + SEG_W'(1);
                    state_next   = S_SCAN_SEG;
                end
            end

            S_SCAN_CMP:
            begin
                if (!(rd_in_range && pend_valid_reg && !out_free))
                begin
                    if (rd_in_range)
                    begin
                        if (pend_valid_reg)
                        begin
                            emit_en        = 1'b1;
                            emit_res.key   = pend_key_reg;
                            emit_res.value = pend_val_reg;
                            emit_res.segs  = 4'(seg_total_reg);
                        end
                        pend_valid_next = 1'b1;
                        pend_key_next   = rd_key_reg;
                        pend_val_next   = rd_val_reg;
                    end
                    slot_next  = slot_reg + ECNT_W'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_SCAN_END:
            begin
                if (pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        emit_en         = 1'b1;
                        emit_res.key    = pend_key_reg;
                        emit_res.value  = pend_val_reg;
                        emit_res.segs   = 4'(seg_total_reg);
                        emit_res.last   = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    resp_next.status = ST_NOT_FOUND;
                    state_next       = S_RESP;
                end
            end

            // merge: check operands, fold b into a, then shift the table down
            S_MRG_CHK:
            begin
                if (merge_bad)
                begin
                    resp_next.status = ST_BAD_SEG;
                    state_next       = S_RESP;
                end
                else
                begin
                    a_seg_next   = (sa_reg < sb_reg) ? SEG_W'(sa_reg) : SEG_W'(sb_reg);
                    b_seg_next   = (sa_reg < sb_reg) ? SEG_W'(sb_reg) : SEG_W'(sa_reg);
                    seg_idx_next = (sa_reg < sb_reg) ? SEG_W'(sa_reg) : SEG_W'(sb_reg);
                    state_next   = S_MRG_A;
                end
            end

            S_MRG_A:
            begin
                a_end_next   = rs_end;
                a_cnt_next   = rs_cnt;
                a_acc_next   = rs_acc;
                a_hot_next   = rs_hot;
                seg_idx_next = b_seg_reg;
                state_next   = S_MRG_B;
            end

            S_MRG_B:
            begin
                if (a_end_reg == '1 || a_end_inc != rs_start)
                begin
                    resp_next.status = ST_BAD_SEG;
                    state_next       = S_RESP;
                end
                else if (cnt_sum > (ECNT_W+1)'(SEGMENT_SLOTS))
                begin
                    resp_next.status = ST_FULL;
                    state_next       = S_RESP;
                end
                else
                begin
                    seg_end_next[a_seg_reg] = rs_end;
                    seg_cnt_next[a_seg_reg] = ECNT_W'(cnt_sum);
                    seg_acc_next[a_seg_reg] = acc_sat;
                    seg_hot_next[a_seg_reg] = a_hot_reg || rs_hot;
                    slot_next  = '0;
                    state_next = S_MRG_RD;
                end
            end

            S_MRG_RD:
            begin
                if (slot_lt_cnt)
                begin
                    state_next = S_MRG_WR;
                end
                else if (last_seg)
                begin
                    seg_total_next = seg_total_reg - CNT_W'(1);
                    state_next     = S_RESP;
                end
                else
                begin
                    // a_seg now walks the destination rows of the shift
                    a_seg_next   = b_seg_reg;
                    seg_idx_next = b_seg_reg + SEG_W'(1);
                    state_next   = S_SHF_TAB;
                end
            end

            S_MRG_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = slot_addr(a_seg_reg, a_cnt_reg + slot_reg);
                slot_next  = slot_reg + ECNT_W'(1);
                state_next = S_MRG_RD;
            end

            S_SHF_TAB:
            begin
                seg_start_next[a_seg_reg] = rs_start;
                seg_end_next[a_seg_reg]   = rs_end;
                seg_cnt_next[a_seg_reg]   = rs_cnt;
                seg_acc_next[a_seg_reg]   = rs_acc;
                seg_hot_next[a_seg_reg]   = rs_hot;
                slot_next  = '0;
                state_next = S_SHF_RD;
            end

            S_SHF_RD:
            begin
                if (slot_lt_cnt)
                begin
                    state_next = S_SHF_WR;
                end
                else if (last_seg)
                begin
                    seg_total_next = seg_total_reg - CNT_W'(1);
                    state_next     = S_RESP;
                end
                else
                begin
                    a_seg_next   = a_seg_reg + SEG_W'(1);
                    seg_idx_next = seg_idx_reg + SEG_W'(1);
                    state_next   = S_SHF_TAB;
                end
            end

            S_SHF_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = slot_addr(a_seg_reg, slot_reg);
                slot_next  = slot_reg + ECNT_W'(1);
                state_next = S_SHF_RD;
            end

            S_INFO:
            begin
                if (info_bad)
                begin
                    resp_next.status = ST_BAD_SEG;
                end
                else
                begin
                    resp_next.key     = rs_start;
                    resp_next.key_end = rs_end;
                    resp_next.ents    = 4'(rs_cnt);
                    resp_next.acc     = rs_acc;
                    resp_next.hot     = rs_hot;
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    emit_en       = 1'b1;
                    emit_res      = resp_reg;
                    emit_res.segs = 4'(seg_total_reg);
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // output register: load on emit, drop after the transfer
        res_next = emit_en ? emit_res : res_reg;
        if (emit_en)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            seg_total_reg  <= CNT_W'(1);
            split_cap_reg  <= SPLIT_CAP_RESET;
            hot_thr_reg    <= HOT_THR_RESET;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_SEGMENTS; i++)
            begin
                seg_start_reg[i] <= '0;
                seg_end_reg[i]   <= (i == 0) ? '1 : '0;
                seg_cnt_reg[i]   <= '0;
                seg_acc_reg[i]   <= '0;
                seg_hot_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            seg_total_reg  <= seg_total_next;
            split_cap_reg  <= split_cap_next;
            hot_thr_reg    <= hot_thr_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            seg_start_reg  <= seg_start_next;
            seg_end_reg    <= seg_end_next;
            seg_cnt_reg    <= seg_cnt_next;
            seg_acc_reg    <= seg_acc_next;
            seg_hot_reg    <= seg_hot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        khi_reg      <= khi_next;
        val_reg      <= val_next;
        sa_reg       <= sa_next;
        sb_reg       <= sb_next;
        seg_idx_reg  <= seg_idx_next;
        slot_reg     <= slot_next;
        pos_reg      <= pos_next;
        found_reg    <= found_next;
        diff_reg     <= diff_next;
        mid_reg      <= mid_next;
        keep_reg     <= keep_next;
        moved_reg    <= moved_next;
        a_seg_reg    <= a_seg_next;
        b_seg_reg    <= b_seg_next;
        a_end_reg    <= a_end_next;
        a_cnt_reg    <= a_cnt_next;
        a_acc_reg    <= a_acc_next;
        a_hot_reg    <= a_hot_next;
        pend_key_reg <= pend_key_next;
        pend_val_reg <= pend_val_next;
        resp_reg     <= resp_next;
        res_reg      <= res_next;
    end

    // entry store with one write port and one read port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_keys_mem[mem_waddr]   <= mem_wkey;
            entry_values_mem[mem_waddr] <= mem_wval;
        end
        rd_key_reg <= entry_keys_mem[mem_raddr];
        rd_val_reg <= entry_values_mem[mem_raddr];
    end

    assign out_valid          = out_valid_reg;
    assign status             = res_reg.status;
    assign out_key            = res_reg.key;
    assign out_key_end        = res_reg.key_end;
    assign out_value          = res_reg.value;
    assign segments_in_use    = res_reg.segs;
    assign entries_in_segment = res_reg.ents;
    assign access_total       = res_reg.acc;
    assign hot_mark           = res_reg.hot;
    assign last               = res_reg.last;

    // a taken command always leaves idle
    `SRKV_ASSERT_NXT(a_accept_busy, in_xfer, state_reg != S_IDLE)
    // segment count stays within the table
    `SRKV_ASSERT_IMP(a_total_range, 1'b1, seg_total_reg != '0 && seg_total_reg <= CNT_W'(MAX_SEGMENTS))
    // the sequencer never overwrites a result still waiting
    `SRKV_ASSERT_IMP(a_emit_free, emit_en, !out_valid_reg || !out_stall)
    // finishing a split adds exactly one segment
    `SRKV_ASSERT_NXT(a_split_grows, state_reg == S_SPLIT_RD && !slot_lt_cnt, seg_total_reg == $past(seg_total_reg) + CNT_W'(1))

endmodule
